// ----- hdl/hsk_pkg.sv -----
`default_nettype none

package hsk_pkg;

  // input beat kind carried on tuser
  typedef enum logic {
    OP_KEY = 1'b0,
    OP_END = 1'b1
  } opcode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_LAYOUT = 2'd0,
    CFG_FN     = 2'd1,
    CFG_BRIGHT = 2'd2,
    CFG_STYLE  = 2'd3
  } cfg_idx_e;

  // layout variants, the spare code decodes like the sixty percent board
  typedef enum logic [1:0] {
    LAY_SIXTY = 2'd0,
    LAY_FULL  = 2'd1,
    LAY_V2    = 2'd2
  } layout_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_PLACE,
    ST_EMIT
  } state_e;

  // media usage page tag
  localparam logic [15:0] MEDIA_MASK = 16'hFF00;
  localparam logic [15:0] MEDIA_TAG  = 16'hE400;

  // field widths
  localparam int unsigned KEY_W  = 17;
  localparam int unsigned MASK_W = 8;
  localparam int unsigned USE_W  = 8;
  localparam int unsigned IN_W   = 48;
  localparam int unsigned OUT_W  = 80;

  // commands from controller to datapath
  typedef struct packed {
    logic key_load;
    logic scan_start;
    logic rel_en;
    logic place_en;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_busy;
  } stat_t;

  // two keys are the same when primary and alt flag match, and alt too if present
  function automatic logic key_eq(
    input logic signed [KEY_W-1:0] p1,
    input logic signed [KEY_W-1:0] a1,
    input logic                    h1,
    input logic signed [KEY_W-1:0] p2,
    input logic signed [KEY_W-1:0] a2,
    input logic                    h2
  );
    key_eq = (p1 == p2) && (h1 == h2) && (!h1 || (a1 == a2));
  endfunction

endpackage

`default_nettype wire

// ----- hdl/hsk_ctrl.sv -----
`default_nettype none

module hsk_ctrl #(
  parameter int unsigned REPORT_SLOTS = 6,
  parameter int unsigned CNT_W        = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_opcode_i,
  output logic                     in_ready_o,
  input  wire logic [CNT_W-1:0]    scan_fill_i,
  input  wire hsk_pkg::stat_t      stat_i,
  output hsk_pkg::cmd_t            cmd_o,
  output logic [CNT_W-1:0]         idx_o
);

  hsk_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             in_beat;
  logic             end_beat;

  assign in_beat  = in_valid_i && (state_q == hsk_pkg::ST_IDLE);
  assign end_beat = in_beat && (in_opcode_i == hsk_pkg::OP_END);

  // next state and walk index
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      hsk_pkg::ST_IDLE: begin
        if (end_beat) begin
          state_d = hsk_pkg::ST_RELEASE;
          idx_d   = '0;
        end
      end
      hsk_pkg::ST_RELEASE: begin
        if (idx_q == CNT_W'(REPORT_SLOTS - 1)) begin
          state_d = hsk_pkg::ST_PLACE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      hsk_pkg::ST_PLACE: begin
        if (idx_q < scan_fill_i) begin
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = hsk_pkg::ST_EMIT;
        end
      end
      hsk_pkg::ST_EMIT: begin
        if (!stat_i.out_busy) begin
          state_d = hsk_pkg::ST_IDLE;
        end
      end
      default: state_d = hsk_pkg::ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hsk_pkg::ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.key_load   = in_beat && (in_opcode_i == hsk_pkg::OP_KEY);
        cmd_o.scan_start = end_beat;
      end
      hsk_pkg::ST_RELEASE: cmd_o.rel_en = 1'b1;
      hsk_pkg::ST_PLACE:   cmd_o.place_en = (idx_q < scan_fill_i);
      hsk_pkg::ST_EMIT:    cmd_o.emit = !stat_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  assign idx_o = idx_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsk_pkg::ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hsk_datapath.sv -----
`default_nettype none

module hsk_datapath #(
  parameter int unsigned REPORT_SLOTS = 6,
  parameter int unsigned CNT_W        = 3,
  parameter int unsigned IDX_W        = 3
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_index_i,
  input  wire logic [hsk_pkg::KEY_W-1:0]    cfg_data_i,
  // input payload
  input  wire logic [hsk_pkg::IN_W-1:0]     in_data_i,
  // control
  input  wire hsk_pkg::cmd_t                cmd_i,
  input  wire logic [CNT_W-1:0]             idx_i,
  output hsk_pkg::stat_t                    stat_o,
  output logic [CNT_W-1:0]                  scan_fill_o,
  // report output
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [hsk_pkg::OUT_W-1:0]         out_data_o
);

  localparam int unsigned KW = hsk_pkg::KEY_W;

  // configuration registers
  logic [1:0]           layout_q;
  logic signed [KW-1:0] fn_key_q;
  logic signed [KW-1:0] bright_key_q;
  logic signed [KW-1:0] style_key_q;

  // report slots
  logic signed [KW-1:0]          slot_pri_q  [REPORT_SLOTS];
  logic signed [KW-1:0]          slot_alt_q  [REPORT_SLOTS];
  logic                          slot_halt_q [REPORT_SLOTS];
  logic [hsk_pkg::USE_W-1:0]     slot_use_q  [REPORT_SLOTS];
  logic [REPORT_SLOTS-1:0]       slot_vld_q;

  // scan list
  logic signed [KW-1:0] scan_pri_q  [REPORT_SLOTS];
  logic signed [KW-1:0] scan_alt_q  [REPORT_SLOTS];
  logic                 scan_halt_q [REPORT_SLOTS];
  logic [CNT_W-1:0]     scan_fill_q;

  // per-scan flags
  logic                        fn_held_q;
  logic [hsk_pkg::MASK_W-1:0]  mod_q;
  logic                        media_held_q;
  logic signed [KW-1:0]        media_pri_q;
  logic signed [KW-1:0]        media_alt_q;
  logic                        media_halt_q;
  logic                        bright_q;
  logic                        style_q;
  logic [CNT_W-1:0]            rel_cnt_q;

  // output register
  logic                        out_vld_q;
  logic [hsk_pkg::OUT_W-1:0]   out_data_q;
  logic [hsk_pkg::OUT_W-1:0]   report_d;

  // input fields
  logic signed [KW-1:0]        in_pri;
  logic signed [KW-1:0]        in_alt;
  logic                        in_halt;
  logic [hsk_pkg::MASK_W-1:0]  in_mask;

  assign in_pri  = in_data_i[16:0];
  assign in_alt  = in_data_i[33:17];
  assign in_halt = in_data_i[34];
  assign in_mask = in_data_i[42:35];

  // layout decode, spare code acts as sixty percent
  logic lay_full, lay_v2, lay_sixty;
  always_comb begin
    lay_full  = 1'b0;
    lay_v2    = 1'b0;
    lay_sixty = 1'b0;
    unique case (layout_q)
      hsk_pkg::LAY_FULL: lay_full = 1'b1;
      hsk_pkg::LAY_V2:   lay_v2 = 1'b1;
      default:           lay_sixty = 1'b1;
    endcase
  end

  logic [IDX_W-1:0] widx;
  assign widx = idx_i[IDX_W-1:0];

  // release check: does the slot under the walk index still appear in the scan list
  logic slot_keep;
  always_comb begin
    slot_keep = 1'b0;
    for (int j = 0; j < REPORT_SLOTS; j++) begin
      if ((CNT_W'(j) < scan_fill_q) &&
          hsk_pkg::key_eq(slot_pri_q[widx], slot_alt_q[widx], slot_halt_q[widx],
                          scan_pri_q[j], scan_alt_q[j], scan_halt_q[j])) begin
        slot_keep = 1'b1;
      end
    end
  end

  // place check: scan entry against held slots, and the lowest free slot
  logic             place_hit;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    place_hit  = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = 0; s < REPORT_SLOTS; s++) begin
      if (slot_vld_q[s]) begin
        if (hsk_pkg::key_eq(slot_pri_q[s], slot_alt_q[s], slot_halt_q[s],
                            scan_pri_q[widx], scan_alt_q[widx], scan_halt_q[widx])) begin
          place_hit = 1'b1;
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(s);
      end
    end
  end

  logic do_place;
  logic do_release;
  assign do_place   = cmd_i.place_en && !place_hit && free_found;
  assign do_release = cmd_i.rel_en && slot_vld_q[widx] && !slot_keep;

  // key classification
  logic is_fn, is_bright, is_style, is_mod, is_consumer, is_regular;
  always_comb begin
    is_fn       = (in_pri == fn_key_q);
    is_bright   = !is_fn && lay_full && (in_pri == bright_key_q);
    is_style    = !is_fn && !is_bright && !lay_sixty && (in_pri == style_key_q);
    is_mod      = !is_fn && !is_bright && !is_style && in_pri[KW-1];
    is_consumer = !is_fn && !is_bright && !is_style && !is_mod &&
                  ((in_pri[15:0] & hsk_pkg::MEDIA_MASK) == hsk_pkg::MEDIA_TAG);
    is_regular  = !is_fn && !is_bright && !is_style && !is_mod && !is_consumer;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q     <= '0;
      fn_key_q     <= '0;
      bright_key_q <= '0;
      style_key_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (hsk_pkg::cfg_idx_e'(cfg_index_i))
        hsk_pkg::CFG_LAYOUT: layout_q <= cfg_data_i[1:0];
        hsk_pkg::CFG_FN:     fn_key_q <= cfg_data_i;
        hsk_pkg::CFG_BRIGHT: bright_key_q <= cfg_data_i;
        hsk_pkg::CFG_STYLE:  style_key_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_fill_q  <= '0;
      fn_held_q    <= 1'b0;
      mod_q        <= '0;
      media_held_q <= 1'b0;
      media_pri_q  <= '0;
      media_alt_q  <= '0;
      media_halt_q <= 1'b0;
      bright_q     <= 1'b0;
      style_q      <= 1'b0;
      rel_cnt_q    <= '0;
    end else if (cmd_i.emit) begin
      scan_fill_q  <= '0;
      fn_held_q    <= 1'b0;
      mod_q        <= '0;
      media_held_q <= 1'b0;
      media_pri_q  <= '0;
      media_alt_q  <= '0;
      media_halt_q <= 1'b0;
      bright_q     <= 1'b0;
      style_q      <= 1'b0;
    end else if (cmd_i.key_load) begin
      if (is_fn) fn_held_q <= 1'b1;
      if (is_bright) bright_q <= 1'b1;
      if (is_style) style_q <= 1'b1;
      if (is_mod) begin
        mod_q <= mod_q | in_mask;
        if (lay_sixty && (in_pri == bright_key_q)) bright_q <= 1'b1;
        if (lay_sixty && (in_pri == style_key_q)) style_q <= 1'b1;
      end
      if (is_consumer) begin
        media_held_q <= 1'b1;
        media_pri_q  <= in_pri;
        media_alt_q  <= in_halt ? in_alt : '0;
        media_halt_q <= in_halt;
      end
      if (is_regular && (scan_fill_q < CNT_W'(REPORT_SLOTS))) begin
        scan_fill_q <= scan_fill_q + 1'b1;
      end
    end else if (cmd_i.scan_start) begin
      rel_cnt_q <= '0;
    end else if (do_release) begin
      rel_cnt_q <= rel_cnt_q + 1'b1;
    end
  end

  // scan list entries, written in fill order
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_load && is_regular && (scan_fill_q < CNT_W'(REPORT_SLOTS))) begin
      scan_pri_q[scan_fill_q[IDX_W-1:0]]  <= in_pri;
      scan_alt_q[scan_fill_q[IDX_W-1:0]]  <= in_halt ? in_alt : '0;
      scan_halt_q[scan_fill_q[IDX_W-1:0]] <= in_halt;
    end
  end

  // slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
    end else if (do_release) begin
      slot_vld_q[widx] <= 1'b0;
    end else if (do_place) begin
      slot_vld_q[free_idx] <= 1'b1;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    if (do_place) begin
      slot_pri_q[free_idx]  <= scan_pri_q[widx];
      slot_alt_q[free_idx]  <= scan_alt_q[widx];
      slot_halt_q[free_idx] <= scan_halt_q[widx];
      slot_use_q[free_idx]  <= (scan_halt_q[widx] && fn_held_q) ?
                               scan_alt_q[widx][7:0] : scan_pri_q[widx][7:0];
    end
  end

  // report assembly
  logic        rep_bright;
  logic        rep_style;
  logic [15:0] rep_media;
  always_comb begin
    rep_bright = bright_q;
    rep_style  = style_q;
    if (lay_v2 && style_q && fn_held_q) begin
      rep_style  = 1'b0;
      rep_bright = 1'b1;
    end
    if (lay_sixty) begin
      rep_bright = rep_bright && fn_held_q;
      rep_style  = rep_style && fn_held_q;
    end else if (lay_v2) begin
      rep_bright = rep_bright && fn_held_q;
    end
    rep_media = '0;
    if (media_held_q) begin
      rep_media = (media_halt_q && fn_held_q) ? media_alt_q[15:0] : media_pri_q[15:0];
    end
  end

  for (genvar s = 0; s < 6; s++) begin : g_slot_out
    if (s < REPORT_SLOTS) begin : g_used
      assign report_d[s*8 +: 8] = slot_vld_q[s] ? slot_use_q[s] : '0;
    end else begin : g_unused
      assign report_d[s*8 +: 8] = '0;
    end
  end
  assign report_d[55:48] = mod_q;
  assign report_d[71:56] = rep_media;
  assign report_d[72]    = rep_bright;
  assign report_d[73]    = rep_style;
  assign report_d[76:74] = 3'(rel_cnt_q);
  assign report_d[79:77] = '0;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= report_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_data_o      = out_data_q;
  assign stat_o.out_busy = out_vld_q && !out_ready_i;
  assign scan_fill_o     = scan_fill_q;

endmodule

`default_nettype wire

// ----- hdl/hid_six_key_report_builder.sv -----
// Six-key keyboard report builder.
// Input stream: one beat per pressed key of a matrix scan (tuser = 0),
// then one end-of-scan beat (tuser = 1). tdata carries key_value,
// alt_value, has_alt and modifier_mask of the key.
// Output stream: one 80-bit report beat per end-of-scan beat, with six
// slot usage codes, modifier byte, media usage, brightness and style
// requests and the count of slots freed at this scan.
// A pressed-key beat is taken while the input is open; the next beat may
// follow at once. An end-of-scan beat starts a walk: the release step
// compares each slot against the whole scan list, the place step puts new
// keys of the list in the lowest free slot and then closes the walk, and
// the emit step loads the report; s_axis_tready is low during the walk.
// The report sits in an output register, so key beats of the next scan
// are taken while it waits; a new report waits for the old one to drain
// when the receiver stalls. Configuration writes are always taken.
// Reset empties all slots and clears the scan state and the output register.
`default_nettype none

module hid_six_key_report_builder #(
  parameter int unsigned REPORT_SLOTS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  // key beats
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // key_value[16:0], alt_value[33:17], has_alt[34], modifier_mask[42:35]
  input  wire logic [47:0] s_axis_tdata_i,
  // opcode[0]
  input  wire logic        s_axis_tuser_i,
  // report beats
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // slot0..5_usage[47:0], modifier_byte[55:48], media_usage[71:56],
  // brightness_up[72], style_change[73], released_count[76:74]
  output logic [79:0]      m_axis_tdata_o
);

  localparam int unsigned CNT_W = $clog2(REPORT_SLOTS + 1);
  localparam int unsigned IDX_W = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;

  hsk_pkg::cmd_t    cmd;
  hsk_pkg::stat_t   stat;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] scan_fill;

  assign cfg_ready_o = 1'b1;

  hsk_ctrl #(
    .REPORT_SLOTS (REPORT_SLOTS),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_opcode_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .scan_fill_i (scan_fill),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .idx_o       (idx)
  );

  hsk_datapath #(
    .REPORT_SLOTS (REPORT_SLOTS),
    .CNT_W        (CNT_W),
    .IDX_W        (IDX_W)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .stat_o      (stat),
    .scan_fill_o (scan_fill),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

// ----- hdl/hsk_checker.sv -----
`default_nettype none

module hsk_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [79:0] m_axis_tdata_o
);

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // an end-of-scan beat starts the slot walk, so input closes next cycle
  a_end_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (s_axis_tuser_i == hsk_pkg::OP_END)) |=> !s_axis_tready_o)
    else $error("input still open after end-of-scan beat");

  // a pressed-key beat never produces a report
  a_key_no_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (s_axis_tuser_i == hsk_pkg::OP_KEY) && !m_axis_tvalid_o) |=>
    !m_axis_tvalid_o)
    else $error("report raised by a pressed-key beat");

  // a stalled report holds its contents
  a_report_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled report changed");

  // no more slots can be freed than exist
  a_released_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[76:74] != 3'd7))
    else $error("released count out of range");

endmodule

bind hid_six_key_report_builder hsk_checker u_hsk_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
